/* sv/rbb_pkg.sv */
package rbb_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int FRAME_WIDTH_RST  = 1024;
  localparam int FRAME_HEIGHT_RST = 1024;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int LINE_W  = 2 * PIX_W;   // {line_two_above, line_above}
  localparam int FW_W    = 11;          // frame_width register
  localparam int FH_W    = 16;          // frame_height register
  localparam int SUM_W   = 12;          // nine 8-bit values

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // x / 9 == (x * 7282) >> 16 for every x below 32768
  localparam int MEAN_RECIP_W = 13;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = 13'd7282;
  localparam int MEAN_SHIFT   = 16;
  localparam int PROD_W       = SUM_W + MEAN_RECIP_W;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            drain;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } pix_out_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } tag_t;

  // item in the line-memory read stage
  typedef struct packed {
    logic             valid;
    logic             fwd;
    logic [PIX_W-1:0] pix;
    tag_t             tag;
  } front_t;

  // window sums on their way to the divider
  typedef struct packed {
    logic             valid;
    logic             interior;
    logic             last;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [PIX_W-1:0] center;
  } mid_t;

  function automatic logic [CH_W-1:0] mean9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
    return prod[MEAN_SHIFT +: CH_W];
  endfunction

endpackage

/* sv/rbb_line_mem.sv */
module rbb_line_mem #(
  parameter  int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic [AW-1:0]             rd_addr,
  output logic [rbb_pkg::LINE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rbb_pkg::LINE_W-1:0] wr_data
);

  logic [rbb_pkg::LINE_W-1:0] mem [0:MAX_WIDTH-1];
  logic [rbb_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/rbb_ctrl.sv */
module rbb_ctrl #(
  parameter  int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbb_pkg::pix_in_t               in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rbb_pkg::CNT_W-1:0]      fill,
  input  logic                           s2_busy,
  input  logic                           s3_busy,
  output logic [AW-1:0]                  rd_addr,
  output rbb_pkg::front_t                s1,
  output logic [AW-1:0]                  s1_col
);

  localparam int RST_W = (rbb_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : rbb_pkg::FRAME_WIDTH_RST;
  localparam int OCC_W = rbb_pkg::CNT_W + 1;

  logic [AW-1:0]              w_m1_r, w_m1_nxt;
  logic [rbb_pkg::FH_W-1:0]   h_m1_r, h_m1_nxt;
  logic [AW-1:0]              in_col_r, in_col_nxt;
  logic [1:0]                 in_row_r, in_row_nxt;
  logic [AW-1:0]              ocol_r, ocol_nxt;
  logic [rbb_pkg::FH_W-1:0]   orow_r, orow_nxt;
  logic                       s1_v_r;
  logic                       s1_fwd_r;
  logic [rbb_pkg::PIX_W-1:0]  s1_pix_r;
  rbb_pkg::tag_t              s1_tag_r;
  logic [AW-1:0]              s1_col_r;

  logic                       accept;
  logic                       cfg_hit;
  logic                       emit, last, interior;
  logic [rbb_pkg::FW_W-1:0]   wv;
  logic [31:0]                wv32;
  logic [OCC_W-1:0]           occ;

  // results already committed: buffered plus still in the pipe
  assign occ = OCC_W'(fill) + OCC_W'(s1_v_r) + OCC_W'(s2_busy) + OCC_W'(s3_busy);
  assign in_stall  = occ >= OCC_W'(rbb_pkg::FIFO_DEPTH);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign cfg_hit   = cfg_valid && (cfg_index == rbb_pkg::REG_FRAME_WIDTH ||
                                   cfg_index == rbb_pkg::REG_FRAME_HEIGHT);

  assign emit     = (in_row_r == 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);
  assign last     = (orow_r == h_m1_r) && (ocol_r == w_m1_r);
  assign interior = (orow_r != '0) && (orow_r != h_m1_r) &&
                    (ocol_r != '0) && (ocol_r != w_m1_r);

  assign wv   = cfg_data[rbb_pkg::FW_W-1:0];
  assign wv32 = 32'(wv);

  always_comb begin
    w_m1_nxt   = w_m1_r;
    h_m1_nxt   = h_m1_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    if (cfg_hit) begin
      if (cfg_index == rbb_pkg::REG_FRAME_WIDTH) begin
        if (wv == '0) begin
          w_m1_nxt = '0;
        end else if (wv32 > 32'(MAX_WIDTH)) begin
          w_m1_nxt = AW'(MAX_WIDTH - 1);
        end else begin
          w_m1_nxt = AW'(wv32 - 32'd1);
        end
      end else begin
        h_m1_nxt = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
      end
      in_col_nxt = '0;
      in_row_nxt = '0;
      ocol_nxt   = '0;
      orow_nxt   = '0;
    end else if (accept) begin
      if (in_col_r == w_m1_r) begin
        in_col_nxt = '0;
        if (in_row_r != 2'd2) begin
          in_row_nxt = in_row_r + 2'd1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          // frame done: next item opens a new frame
          in_col_nxt = '0;
          in_row_nxt = '0;
          ocol_nxt   = '0;
          orow_nxt   = '0;
        end else if (ocol_r == w_m1_r) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r   <= AW'(RST_W - 1);
      h_m1_r   <= rbb_pkg::FH_W'(rbb_pkg::FRAME_HEIGHT_RST - 1);
      in_col_r <= '0;
      in_row_r <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      w_m1_r   <= w_m1_nxt;
      h_m1_r   <= h_m1_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
      s1_v_r   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_data.drain ? '0 :
                  {in_data.red_in, in_data.green_in, in_data.blue_in};
      s1_col_r <= in_col_r;
      s1_tag_r <= '{emit: emit, interior: interior, last: last};
      // previous item writes this column on the same edge as our read
      s1_fwd_r <= s1_v_r && (s1_col_r == in_col_r);
    end
  end

  assign rd_addr  = in_col_r;
  assign s1_col   = s1_col_r;
  assign s1.valid = s1_v_r;
  assign s1.fwd   = s1_fwd_r;
  assign s1.pix   = s1_pix_r;
  assign s1.tag   = s1_tag_r;

endmodule

/* sv/rbb_window.sv */
module rbb_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbb_pkg::front_t            s1,
  input  logic [rbb_pkg::LINE_W-1:0] rd_data,
  output logic                       wr_en,
  output logic [rbb_pkg::LINE_W-1:0] wr_data,
  output logic                       s2_busy,
  output rbb_pkg::mid_t              s3
);

  localparam int PW = rbb_pkg::PIX_W;
  localparam int CW = rbb_pkg::CH_W;
  localparam int SW = rbb_pkg::SUM_W;

  logic [PW-1:0] win_r [0:2][0:2];   // [row][column], column 2 newest
  logic [PW-1:0] fwd_above_r, fwd_two_r;
  logic          s2_v_r;
  logic          s2_interior_r, s2_last_r;
  rbb_pkg::mid_t s3_r;

  logic [PW-1:0] above, two_above;
  logic [SW-1:0] sum_r, sum_g, sum_b;

  assign above     = s1.fwd ? fwd_above_r : rd_data[PW-1:0];
  assign two_above = s1.fwd ? fwd_two_r   : rd_data[2*PW-1:PW];

  assign wr_en   = s1.valid;
  assign wr_data = {above, s1.pix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= two_above;
      win_r[1][2] <= above;
      win_r[2][2] <= s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      fwd_above_r   <= s1.pix;
      fwd_two_r     <= above;
      s2_interior_r <= s1.tag.interior;
      s2_last_r     <= s1.tag.last;
    end
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum_r = sum_r + SW'(win_r[r][c][2*CW +: CW]);
        sum_g = sum_g + SW'(win_r[r][c][CW +: CW]);
        sum_b = sum_b + SW'(win_r[r][c][0 +: CW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r     <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s2_v_r     <= s1.valid && s1.tag.emit;
      s3_r.valid <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_r.interior <= s2_interior_r;
      s3_r.last     <= s2_last_r;
      s3_r.sum_r    <= sum_r;
      s3_r.sum_g    <= sum_g;
      s3_r.sum_b    <= sum_b;
      s3_r.center   <= win_r[1][1];
    end
  end

  assign s2_busy = s2_v_r;
  assign s3      = s3_r;

endmodule

/* sv/rbb_out_fifo.sv */
module rbb_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbb_pkg::mid_t             s3,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rbb_pkg::pix_out_t         out_data,
  output logic [rbb_pkg::CNT_W-1:0] fill
);

  localparam int CW = rbb_pkg::CH_W;

  rbb_pkg::pix_out_t                buf_r [0:rbb_pkg::FIFO_DEPTH-1];
  logic [rbb_pkg::FIFO_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [rbb_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  rbb_pkg::pix_out_t                res;
  logic                             pop;

  always_comb begin
    if (s3.interior) begin
      res.red_out   = rbb_pkg::mean9(s3.sum_r);
      res.green_out = rbb_pkg::mean9(s3.sum_g);
      res.blue_out  = rbb_pkg::mean9(s3.sum_b);
    end else begin
      res.red_out   = s3.center[2*CW +: CW];
      res.green_out = s3.center[CW +: CW];
      res.blue_out  = s3.center[0 +: CW];
    end
    res.frame_end = s3.last;
  end

  assign pop = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (s3.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!s3.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s3.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3.valid) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_data  = buf_r[rd_ptr_r];
  assign fill      = cnt_r;

endmodule

/* sv/rgb_box_blur_3x3.sv */
// 3x3 box blur on an RGB pixel stream in raster order. One item (pixel or drain)
// is taken per clock while in_stall is low; each item passes s1, s2 and s3 before
// its result is buffered, and because a window needs the row below, the result
// for a pixel is produced by the item frame_width + 1 positions later: send
// drain items after the last pixel to flush the tail, the last result carries
// frame_end. Interior pixels get the truncated per-channel mean of the nine
// original neighbours, border pixels pass through. The previous two rows live in
// one line memory (MAX_WIDTH entries of two pixels), read in the cycle before
// the window update; an eight-entry result buffer sits at the output, and
// in_stall is high only while that buffer plus the items in the pipe come to
// eight. Writing either register restarts the frame; cfg_ready is always high.
module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbb_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbb_pkg::pix_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              s1_col;
  rbb_pkg::front_t            s1;
  logic [rbb_pkg::LINE_W-1:0] rd_data;
  logic                       wr_en;
  logic [rbb_pkg::LINE_W-1:0] wr_data;
  logic                       s2_busy;
  rbb_pkg::mid_t              s3;
  logic [rbb_pkg::CNT_W-1:0]  fill;

  rbb_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fill     (fill),
    .s2_busy  (s2_busy),
    .s3_busy  (s3.valid),
    .rd_addr  (rd_addr),
    .s1       (s1),
    .s1_col   (s1_col)
  );

  rbb_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(s1_col),
    .wr_data(wr_data)
  );

  rbb_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1     (s1),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .s2_busy(s2_busy),
    .s3     (s3)
  );

  rbb_out_fifo u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3       (s3),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .fill     (fill)
  );

endmodule

/* sv/rbb_checker.sv */
module rbb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rbb_pkg::pix_out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // nothing is buffered or in flight right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // an empty output only fills from an item taken earlier that has passed s1, s2 and s3
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
    else $error("result without a matching input item");

  // empty output and no item taken that could still be in s1, s2 or s3: the pipe is empty, no stall
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && !in_stall, 1) && !$past(in_valid && !in_stall, 2)
    && !$past(in_valid && !in_stall, 3) |-> !in_stall)
    else $error("input stalled with an empty pipe");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* test/rgb_box_blur_3x3_checker.sv */
`timescale 1ns / 100ps

module rgb_box_blur_3x3_checker #(
  parameter int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  rbb_pkg::pix_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  rbb_pkg::pix_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            results_seen,
  output int                            smoothed_seen,
  output int                            frames_seen
);

  localparam int WINDOW_TAPS = 9;

  logic [rbb_pkg::PIX_W-1:0] line_up  [MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0] line_up2 [MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0] win      [WINDOW_TAPS];
  int unsigned               col_in;
  int unsigned               rows_in;
  int unsigned               next_out;
  logic [rbb_pkg::FW_W-1:0]  width_reg;
  logic [rbb_pkg::FH_W-1:0]  height_reg;
  rbb_pkg::pix_out_t         expected_px [$];
  int                        n_err;
  int                        n_res;
  int                        n_smooth;
  int                        n_frames;

  function automatic void restart_frame();
    foreach (win[k]) win[k] = '0;
    col_in   = 0;
    rows_in  = 0;
    next_out = 0;
  endfunction

  function automatic logic [rbb_pkg::CH_W-1:0] window_mean(input int sh);
    int unsigned sum;
    sum = 0;
    foreach (win[k]) sum += win[k][sh +: rbb_pkg::CH_W];
    return rbb_pkg::CH_W'(sum / WINDOW_TAPS);
  endfunction

  // advance the stream by one item, queue the pixel it completes (if any)
  function automatic void blur_step(input rbb_pkg::pix_in_t it);
    int unsigned               w;
    int unsigned               h;
    int unsigned               c;
    int unsigned               q;
    int unsigned               orow;
    int unsigned               ocol;
    logic [rbb_pkg::PIX_W-1:0] pix;
    logic [rbb_pkg::PIX_W-1:0] above;
    logic [rbb_pkg::PIX_W-1:0] above2;
    logic                      emit;
    logic                      inner;
    rbb_pkg::pix_out_t         res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    pix = it.drain ? '0 : {it.red_in, it.green_in, it.blue_in};
    c = (col_in >= w) ? 0 : col_in;
    above  = line_up[c];
    above2 = line_up2[c];
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = above2;
    win[5] = above;
    win[8] = pix;
    line_up2[c] = above;
    line_up[c]  = pix;
    emit = (rows_in >= 2) || (rows_in == 1 && c >= 1);
    c++;
    if (c >= w) begin
      c = 0;
      if (rows_in < 2) rows_in++;
    end
    col_in = c;
    if (!emit) return;

    q    = next_out;
    orow = q / w;
    ocol = q % w;
    inner = (orow >= 1) && (orow + 2 <= h) && (ocol >= 1) && (ocol + 2 <= w);
    if (inner) begin
      res.red_out   = window_mean(2 * rbb_pkg::CH_W);
      res.green_out = window_mean(rbb_pkg::CH_W);
      res.blue_out  = window_mean(0);
      n_smooth++;
    end else begin
      {res.red_out, res.green_out, res.blue_out} = win[4];
    end
    res.frame_end = (longint'(q) + 1 >= longint'(w) * longint'(h));
    expected_px.push_back(res);
    if (res.frame_end) restart_frame();
    else next_out = (q + 1) & 32'h03FF_FFFF;
  endfunction

  always @(posedge clk) begin : monitor
    rbb_pkg::pix_out_t want;
    if (!rst_n) begin
      foreach (line_up[i]) begin
        line_up[i]  = '0;
        line_up2[i] = '0;
      end
      width_reg  = rbb_pkg::FW_W'(rbb_pkg::FRAME_WIDTH_RST);
      height_reg = rbb_pkg::FH_W'(rbb_pkg::FRAME_HEIGHT_RST);
      restart_frame();
      expected_px.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rbb_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data[rbb_pkg::FW_W-1:0];
          restart_frame();
        end else if (cfg_index == rbb_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_data[rbb_pkg::FH_W-1:0];
          restart_frame();
        end
      end
      if (in_valid && !in_stall) blur_step(in_data);
      if (out_valid && !out_stall) begin
        n_res++;
        if (out_data.frame_end === 1'b1) n_frames++;
        if (expected_px.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: unexpected pixel %02h %02h %02h end %b", $time,
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.frame_end);
        end else begin
          want = expected_px.pop_front();
          if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
              out_data.blue_out !== want.blue_out ||
              out_data.frame_end !== want.frame_end) begin
            n_err++;
            if (n_err <= 10)
              $display("%0t: pixel mismatch: expected %02h %02h %02h end %b, %s",
                       $time, want.red_out, want.green_out, want.blue_out, want.frame_end,
                       $sformatf("got %02h %02h %02h end %b",
                                 out_data.red_out, out_data.green_out, out_data.blue_out,
                                 out_data.frame_end));
          end
        end
      end
    end
    errors        <= n_err;
    pending       <= expected_px.size();
    results_seen  <= n_res;
    smoothed_seen <= n_smooth;
    frames_seen   <= n_frames;
  end

endmodule

/* test/rgb_box_blur_3x3_tb.sv */
`timescale 1ns / 100ps

module rgb_box_blur_3x3_tb;

  localparam logic [rbb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [rbb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SHORT_BURST   = 40;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  rbb_pkg::pix_in_t              in_data;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rbb_pkg::pix_out_t             out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbb_pkg::CFG_W-1:0]     cfg_data;

  int errors;
  int pending;
  int results_seen;
  int smoothed_seen;
  int frames_seen;
  int items_sent;
  int cfg_writes;
  int burst_left;
  int stall_left;
  int stall_tick;
  stall_mode_t stall_mode;

  always #5 clk = ~clk;

  rgb_box_blur_3x3 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgb_box_blur_3x3_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .results_seen  (results_seen),
    .smoothed_seen (smoothed_seen),
    .frames_seen   (frames_seen)
  );

  // output backpressure: a new mode is drawn each time stall_left runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:     out_stall <= stall_tick[2];
    endcase
  end

  function automatic logic [rbb_pkg::CH_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return rbb_pkg::CH_W'($urandom());
    endcase
  endfunction

  function automatic rbb_pkg::pix_in_t make_px(input logic [rbb_pkg::CH_W-1:0] r, g, b,
                                               input logic drain);
    rbb_pkg::pix_in_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.drain    = drain;
    return p;
  endfunction

  task automatic push_item(input rbb_pkg::pix_in_t d);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // items past the last result may still be in the pipe
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rbb_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic send_loose(input int count);
    repeat (count)
      push_item(make_px(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 5) == 0));
  endtask

  task automatic send_frame(input int unsigned ew, eh, input bit noisy);
    int unsigned body;
    int unsigned total;
    bit          dr;
    body  = ew * eh;
    total = body + ew + 1;
    // a cut frame shifts every later frame against the block's counters
    if (noisy && $urandom_range(0, 2) == 0) total = $urandom_range(1, total);
    for (int unsigned i = 0; i < total; i++) begin
      if (!noisy) dr = (i >= body);
      else if (i < body) dr = ($urandom_range(0, 7) == 0);
      else dr = ($urandom_range(0, 2) != 0);
      push_item(make_px(rand_chan(), rand_chan(), rand_chan(), dr));
    end
  endtask

  task automatic run_phase(input int unsigned w_raw, h_raw, input int frames, loose,
                           input bit allow_noise);
    int unsigned ew;
    int unsigned eh;
    quiesce();
    write_reg(rbb_pkg::REG_FRAME_WIDTH,
              {(rbb_pkg::CFG_W-rbb_pkg::FW_W)'($urandom()), rbb_pkg::FW_W'(w_raw)});
    write_reg(rbb_pkg::REG_FRAME_HEIGHT, rbb_pkg::CFG_W'(h_raw));
    ew = rbb_pkg::FW_W'(w_raw);
    if (ew == 0) ew = 1;
    if (ew > rbb_pkg::MAX_WIDTH_DEF) ew = rbb_pkg::MAX_WIDTH_DEF;
    eh = (h_raw == 0) ? 1 : h_raw;
    repeat (frames) begin
      send_frame(ew, eh, allow_noise && ($urandom_range(0, 4) == 0));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    send_loose(loose);
  endtask

  initial begin : stimulus
    int unsigned rw;
    int unsigned rh;
    int          frames;
    int          loose;
    int          start_items;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 1024 wide: a short burst must not produce any result
    send_loose(SHORT_BURST);

    quiesce();
    write_reg(rbb_pkg::REG_FRAME_WIDTH, 16'd3);
    write_reg(rbb_pkg::REG_FRAME_HEIGHT, 16'd3);
    push_item(make_px(8'hff, 8'h00, 8'hff, 1'b0));
    push_item(make_px(8'h00, 8'hff, 8'h00, 1'b0));
    push_item(make_px(8'h80, 8'h7f, 8'h01, 1'b0));
    push_item(make_px(8'hff, 8'hff, 8'hff, 1'b0));
    push_item(make_px(8'h55, 8'haa, 8'h55, 1'b0));
    push_item(make_px(8'haa, 8'h55, 8'haa, 1'b0));
    push_item(make_px(8'h01, 8'hfe, 8'h80, 1'b0));
    push_item(make_px(8'hff, 8'hff, 8'hff, 1'b1));   // drain inside the frame reads as black
    push_item(make_px(8'h00, 8'h00, 8'h00, 1'b0));
    push_item(make_px(8'hff, 8'hff, 8'hff, 1'b0));   // pixels in the tail must not leak
    push_item(make_px(8'h00, 8'h00, 8'h00, 1'b1));
    push_item(make_px(8'h12, 8'h34, 8'h56, 1'b0));
    push_item(make_px(8'h00, 8'h00, 8'h00, 1'b1));
    wait_drained();
    // full-scale frame: largest window sum
    repeat (9) push_item(make_px(8'hff, 8'hff, 8'hff, 1'b0));
    repeat (4) push_item(make_px(8'hff, 8'hff, 8'hff, 1'b1));

    run_phase(0, 0, 3, 0, 1'b0);        // zero width and height act as one
    run_phase(1, 4, 2, 0, 1'b0);
    run_phase(2047, 3, 0, SHORT_BURST, 1'b0);  // clamps to the full line width: no result yet
    run_phase(4, 65535, 0, 90, 1'b0);   // tallest frame, left unfinished
    quiesce();
    write_reg(REG_SPARE_LO, rbb_pkg::CFG_W'($urandom()));
    send_loose(60);                     // unmapped index keeps the frame going
    quiesce();
    write_reg(REG_SPARE_HI, rbb_pkg::CFG_W'($urandom()));
    send_loose(40);
    run_phase(5, 1, 2, 0, 1'b0);

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       rw = $urandom_range(11, 40);
        1:       rw = $urandom_range(0, 1);
        default: rw = $urandom_range(2, 10);
      endcase
      frames = $urandom_range(1, 3);
      loose  = 0;
      case ($urandom_range(0, 9))
        0: rh = 0;
        1: begin
          rh     = 65535;
          frames = 0;
          loose  = $urandom_range(30, 120);
        end
        default: rh = $urandom_range(1, 6);
      endcase
      run_phase(rw, rh, frames, loose, 1'b1);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items with %0d register writes across reset, directed and random frames.",
             items_sent, cfg_writes);
    $display("Checked %0d output pixels (%0d smoothed, %0d frame ends), %0d errors.",
             results_seen, smoothed_seen, frames_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
